FILE: rtl/frlc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frlc_pkg
// Shared sizes, codes and ring helpers of the FIFO-replacement lookup cache.
// ----------------------------------------------------------------------------
package frlc_pkg;

   localparam int ENTRIES     = 64;
   localparam int KEY_WIDTH   = 32;
   localparam int VALUE_WIDTH = 32;

   localparam int ADDR_W  = $clog2(ENTRIES);
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   localparam int SUM_W   = CNT_W + 1;
   localparam int CAP_W   = 7;
   localparam int OCC_W   = 7;
   localparam int COUNT_W = 32;
   localparam int CMP_W   = (CAP_W > CNT_W) ? CAP_W : CNT_W;
   localparam int REQ_W   = 2;
   localparam int OUT_W   = 3;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

   typedef enum logic [REQ_W-1:0] {
      REQ_LOOKUP = 2'd0,
      REQ_INSERT = 2'd1,
      REQ_CLEAR  = 2'd2
   } req_code_type;

   typedef enum logic [OUT_W-1:0] {
      OC_HIT     = 3'd0,
      OC_MISS    = 3'd1,
      OC_STORED  = 3'd2,
      OC_EVICTED = 3'd3,
      OC_IGNORED = 3'd4,
      OC_CLEARED = 3'd5
   } outcome_type;

   // advance a ring slot by one, wrapping at ENTRIES
   function automatic logic [ADDR_W-1:0] ring_next(input logic [ADDR_W-1:0] slot);
      logic [ADDR_W-1:0] res;
      if (CNT_W'(slot) == CNT_W'(ENTRIES - 1)) begin
         res = '0;
      end else begin
         res = slot + ADDR_W'(1);
      end
      return res;
   endfunction

   // slot plus an offset of at most ENTRIES, wrapped once
   function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] slot,
                                                  input logic [CNT_W-1:0]  offs);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(slot) + SUM_W'(offs);
      if (sum >= SUM_W'(ENTRIES)) begin
         sum = sum - SUM_W'(ENTRIES);
      end
      return sum[ADDR_W-1:0];
   endfunction

   // capacity zero acts as one, above ENTRIES acts as ENTRIES
   function automatic logic [CNT_W-1:0] eff_capacity(input logic [CAP_W-1:0] cap);
      logic [CNT_W-1:0] res;
      if (cap == '0) begin
         res = CNT_W'(1);
      end else if (CMP_W'(cap) > CMP_W'(ENTRIES)) begin
         res = CNT_W'(ENTRIES);
      end else begin
         res = CNT_W'(cap);
      end
      return res;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/frlc_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frlc request and response channels
// Valid/ready channels carrying one request item and one response item.
// ----------------------------------------------------------------------------
interface frlc_req_if;
   logic                              valid;
   logic                              ready;
   logic [frlc_pkg::REQ_W-1:0]        req_type;
   logic [frlc_pkg::KEY_WIDTH-1:0]    lookup_key;
   logic [frlc_pkg::VALUE_WIDTH-1:0]  value_in;

   modport source (output valid, output req_type, output lookup_key, output value_in,
                   input ready);
   modport sink   (input valid, input req_type, input lookup_key, input value_in,
                   output ready);
endinterface

interface frlc_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [frlc_pkg::OUT_W-1:0]        outcome;
   logic [frlc_pkg::VALUE_WIDTH-1:0]  value_out;
   logic [frlc_pkg::COUNT_W-1:0]      hit_count;
   logic [frlc_pkg::COUNT_W-1:0]      miss_count;
   logic [frlc_pkg::OCC_W-1:0]        occupancy;

   modport source (output valid, output outcome, output value_out, output hit_count,
                   output miss_count, output occupancy, input ready);
   modport sink   (input valid, input outcome, input value_out, input hit_count,
                   input miss_count, input occupancy, output ready);
endinterface
`default_nettype wire

FILE: rtl/frlc_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frlc_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module frlc_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 64
) (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  wire logic [WIDTH-1:0]          wr_data,
   input  wire logic                      rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]  rd_addr,
   output      logic [WIDTH-1:0]          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

FILE: rtl/fifo_replacement_lookup_cache.sv
// Lookups and inserts walk the live entries through the key/value RAM's single read
//   port (a hit ends the walk early); clear and undefined requests skip the walk.
// One request is handled at a time: a new one is accepted only once the last has
//   been committed to the response register and the cache is idle again.
// Reset: synchronous, active high; clears counters and ring pointers and sets the
//   capacity to 64. RAM contents are not cleared: the fill count marks live entries.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fifo_replacement_lookup_cache
// Fully associative key/value cache with FIFO replacement and hit/miss counters.
// ----------------------------------------------------------------------------
module fifo_replacement_lookup_cache (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_wr_en,
   input  wire logic [frlc_pkg::CAP_W-1:0]  csr_wr_data,
   frlc_req_if.sink                         req_ch,
   frlc_rsp_if.source                       rsp_ch
);

   localparam int DATA_W = frlc_pkg::KEY_WIDTH + frlc_pkg::VALUE_WIDTH;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_FINISH
   } state_type;

   state_type                          state_ff, state_in;
   logic [frlc_pkg::CAP_W-1:0]         cap_ff, cap_in;
   logic [frlc_pkg::CNT_W-1:0]         fill_ff, fill_in;
   logic [frlc_pkg::ADDR_W-1:0]        oldest_ff, oldest_in;
   logic [frlc_pkg::COUNT_W-1:0]       hit_cnt_ff, hit_cnt_in;
   logic [frlc_pkg::COUNT_W-1:0]       miss_cnt_ff, miss_cnt_in;
   logic [frlc_pkg::CNT_W-1:0]         idx_ff, idx_in;
   logic [frlc_pkg::ADDR_W-1:0]        ptr_ff, ptr_in;
   logic                               pend_ff, pend_in;
   logic                               found_ff, found_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [frlc_pkg::OUT_W-1:0]         outcome_ff, outcome_in;
   logic [frlc_pkg::VALUE_WIDTH-1:0]   value_out_ff, value_out_in;

   logic [frlc_pkg::REQ_W-1:0]         kind_ff;
   logic [frlc_pkg::KEY_WIDTH-1:0]     key_ff;
   logic [frlc_pkg::VALUE_WIDTH-1:0]   val_ff;
   logic [frlc_pkg::VALUE_WIDTH-1:0]   found_val_ff;

   logic                               accept;
   logic                               commit;
   logic                               issue;
   logic                               key_match;
   logic                               evict;

   logic                               rd_en;
   logic [frlc_pkg::ADDR_W-1:0]        rd_addr;
   logic [DATA_W-1:0]                  rd_data;
   logic                               wr_en;
   logic [frlc_pkg::ADDR_W-1:0]        wr_addr;
   logic [DATA_W-1:0]                  wr_data;

   frlc_ram #(
      .DEPTH (frlc_pkg::ENTRIES),
      .WIDTH (DATA_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ch.ready      = (state_ff == ST_IDLE);
   assign accept            = req_ch.valid && (state_ff == ST_IDLE);

   // counters and fill only move at commit, so they match the held response
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.outcome    = outcome_ff;
   assign rsp_ch.value_out  = value_out_ff;
   assign rsp_ch.hit_count  = hit_cnt_ff;
   assign rsp_ch.miss_count = miss_cnt_ff;
   assign rsp_ch.occupancy  = frlc_pkg::OCC_W'(fill_ff);

   assign issue     = (idx_ff < fill_ff);
   assign key_match = pend_ff &&
                      (rd_data[frlc_pkg::VALUE_WIDTH +: frlc_pkg::KEY_WIDTH] == key_ff);
   assign evict     = (fill_ff >= frlc_pkg::eff_capacity(cap_ff));

   always_comb begin
      state_in     = state_ff;
      cap_in       = csr_wr_en ? csr_wr_data : cap_ff;
      fill_in      = fill_ff;
      oldest_in    = oldest_ff;
      hit_cnt_in   = hit_cnt_ff;
      miss_cnt_in  = miss_cnt_ff;
      idx_in       = idx_ff;
      ptr_in       = ptr_ff;
      pend_in      = pend_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      outcome_in   = outcome_ff;
      value_out_in = value_out_ff;
      commit       = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = ptr_ff;
      wr_en        = 1'b0;
      wr_addr      = frlc_pkg::ring_add(oldest_ff, fill_ff);
      wr_data      = {key_ff, val_ff};

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               idx_in   = '0;
               ptr_in   = oldest_ff;
               pend_in  = 1'b0;
               found_in = 1'b0;
               if (req_ch.req_type == frlc_pkg::REQ_LOOKUP ||
                   req_ch.req_type == frlc_pkg::REQ_INSERT) begin
                  state_in = ST_SEARCH;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_SEARCH: begin
            // walk the live ring one slot a cycle, compare each read in the cycle after it
            rd_en = issue;
            if (key_match) begin
               found_in = 1'b1;
               pend_in  = 1'b0;
               state_in = ST_FINISH;
            end else if (!issue) begin
               pend_in  = 1'b0;
               state_in = ST_FINISH;
            end else begin
               pend_in = 1'b1;
               idx_in  = idx_ff + frlc_pkg::CNT_W'(1);
               ptr_in  = frlc_pkg::ring_next(ptr_ff);
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               commit       = 1'b1;
               rsp_valid_in = 1'b1;
               value_out_in = '0;
               state_in     = ST_IDLE;
               case (kind_ff)
                  frlc_pkg::REQ_LOOKUP: begin
                     if (found_ff) begin
                        outcome_in   = frlc_pkg::OC_HIT;
                        value_out_in = found_val_ff;
                        if (hit_cnt_ff != '1) begin
                           hit_cnt_in = hit_cnt_ff + frlc_pkg::COUNT_W'(1);
                        end
                     end else begin
                        outcome_in = frlc_pkg::OC_MISS;
                        if (miss_cnt_ff != '1) begin
                           miss_cnt_in = miss_cnt_ff + frlc_pkg::COUNT_W'(1);
                        end
                     end
                  end
                  frlc_pkg::REQ_INSERT: begin
                     if (found_ff) begin
                        outcome_in = frlc_pkg::OC_IGNORED;
                     end else begin
                        // new entry lands at oldest + fill either way
                        wr_en = 1'b1;
                        if (evict) begin
                           outcome_in = frlc_pkg::OC_EVICTED;
                           oldest_in  = frlc_pkg::ring_next(oldest_ff);
                        end else begin
                           outcome_in = frlc_pkg::OC_STORED;
                           fill_in    = fill_ff + frlc_pkg::CNT_W'(1);
                        end
                     end
                  end
                  frlc_pkg::REQ_CLEAR: begin
                     outcome_in  = frlc_pkg::OC_CLEARED;
                     fill_in     = '0;
                     oldest_in   = '0;
                     hit_cnt_in  = '0;
                     miss_cnt_in = '0;
                  end
                  default: begin
                     outcome_in = frlc_pkg::OC_IGNORED;
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= frlc_pkg::CAP_RESET;
         fill_ff      <= '0;
         oldest_ff    <= '0;
         hit_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
         idx_ff       <= '0;
         ptr_ff       <= '0;
         pend_ff      <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         outcome_ff   <= frlc_pkg::OC_IGNORED;
         value_out_ff <= '0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         fill_ff      <= fill_in;
         oldest_ff    <= oldest_in;
         hit_cnt_ff   <= hit_cnt_in;
         miss_cnt_ff  <= miss_cnt_in;
         idx_ff       <= idx_in;
         ptr_ff       <= ptr_in;
         pend_ff      <= pend_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
         outcome_ff   <= outcome_in;
         value_out_ff <= value_out_in;
      end
   end

   // request payload and matched value, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= req_ch.req_type;
         key_ff  <= req_ch.lookup_key;
         val_ff  <= req_ch.value_in;
      end
      if (state_ff == ST_SEARCH && key_match) begin
         found_val_ff <= rd_data[frlc_pkg::VALUE_WIDTH-1:0];
      end
   end

`ifndef SYNTH
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= frlc_pkg::CNT_W'(frlc_pkg::ENTRIES))
      else $error("fill count above entry count");

   a_read_in_ring: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> (idx_ff < fill_ff && state_ff == ST_SEARCH))
      else $error("store read outside the live ring");

   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rd_en && wr_en))
      else $error("store read and write in the same cycle");

   a_counters_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.ready) |=> ($stable(hit_cnt_ff) && $stable(miss_cnt_ff)
                                           && $stable(fill_ff)))
      else $error("counters moved under a stalled response");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (commit && kind_ff == frlc_pkg::REQ_CLEAR) |=> (fill_ff == '0 && hit_cnt_ff == '0))
      else $error("clear left entries or hits behind");
`endif

endmodule
`default_nettype wire

FILE: test/fifo_replacement_lookup_cache_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_replacement_lookup_cache_tb
// Drives lookup, insert, clear and undefined requests into the cache. A shadow
// copy of the ring store predicts every response, and each response is
// checked against that prediction. The capacity register is swept across
// its extremes, and both sides of the handshake stall at random.
// ----------------------------------------------------------------------------
module fifo_replacement_lookup_cache_tb;

   localparam logic [frlc_pkg::REQ_W-1:0] REQ_UNDEFINED = 2'd3;
   localparam int unsigned CYCLE_LIMIT   = 1_000_000;
   localparam int unsigned PHASE_ITEMS   = 238;
   localparam int unsigned PHASE_COUNT   = 8;
   localparam int unsigned SETTLE_CYCLES = frlc_pkg::ENTRIES + 16;
   localparam int unsigned RECENT_DEPTH  = 128;
   localparam int unsigned REPORT_LIMIT  = 10;

   typedef struct {
      frlc_pkg::outcome_type            outcome;
      logic [frlc_pkg::VALUE_WIDTH-1:0] value;
      logic [frlc_pkg::COUNT_W-1:0]     hits;
      logic [frlc_pkg::COUNT_W-1:0]     misses;
      logic [frlc_pkg::OCC_W-1:0]       occupancy;
   } cache_answer_type;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       csr_wr_en;
   logic [frlc_pkg::CAP_W-1:0] csr_wr_data;

   frlc_req_if req_ch();
   frlc_rsp_if rsp_ch();

   fifo_replacement_lookup_cache uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch)
   );

   // shadow copy of the ring store
   logic [frlc_pkg::KEY_WIDTH-1:0]   shadow_key   [frlc_pkg::ENTRIES];
   logic [frlc_pkg::VALUE_WIDTH-1:0] shadow_value [frlc_pkg::ENTRIES];
   bit                               shadow_live  [frlc_pkg::ENTRIES];
   int unsigned                      shadow_oldest;
   int unsigned                      shadow_fill;
   logic [frlc_pkg::COUNT_W-1:0]     shadow_hits;
   logic [frlc_pkg::COUNT_W-1:0]     shadow_misses;
   logic [frlc_pkg::CAP_W-1:0]       shadow_capacity;

   cache_answer_type               pending_answers [$];
   logic [frlc_pkg::KEY_WIDTH-1:0] recent_keys [$];
   int unsigned                    mismatches;
   int unsigned                    cycle_count;
   int unsigned                    stall_left;
   bit                             idling;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int find_entry(input logic [frlc_pkg::KEY_WIDTH-1:0] key);
      for (int i = 0; i < frlc_pkg::ENTRIES; i++) begin
         if (shadow_live[i] && shadow_key[i] == key) begin
            return i;
         end
      end
      return -1;
   endfunction

   function automatic void empty_store();
      for (int i = 0; i < frlc_pkg::ENTRIES; i++) begin
         shadow_live[i] = 1'b0;
      end
      shadow_oldest = 0;
      shadow_fill   = 0;
      shadow_hits   = '0;
      shadow_misses = '0;
   endfunction

   // apply one request to the shadow store and return the response it causes
   function automatic cache_answer_type cache_answer(
         input logic [frlc_pkg::REQ_W-1:0]       kind,
         input logic [frlc_pkg::KEY_WIDTH-1:0]   key,
         input logic [frlc_pkg::VALUE_WIDTH-1:0] val);
      cache_answer_type ans;
      int               slot;
      int unsigned      limit;
      int unsigned      wr;
      ans.outcome = frlc_pkg::OC_IGNORED;
      ans.value   = '0;
      case (kind)
         frlc_pkg::REQ_LOOKUP: begin
            slot = find_entry(key);
            if (slot >= 0) begin
               ans.outcome = frlc_pkg::OC_HIT;
               ans.value   = shadow_value[slot];
               if (shadow_hits != '1) shadow_hits++;
            end else begin
               ans.outcome = frlc_pkg::OC_MISS;
               if (shadow_misses != '1) shadow_misses++;
            end
         end
         frlc_pkg::REQ_INSERT: begin
            if (find_entry(key) < 0) begin
               limit = (shadow_capacity == 0) ? 1 :
                       (shadow_capacity > frlc_pkg::ENTRIES) ? frlc_pkg::ENTRIES :
                       shadow_capacity;
               ans.outcome = frlc_pkg::OC_STORED;
               // evict only one, even when capacity was lowered below occupancy
               if (shadow_fill >= limit) begin
                  shadow_live[shadow_oldest] = 1'b0;
                  shadow_oldest = (shadow_oldest + 1) % frlc_pkg::ENTRIES;
                  shadow_fill--;
                  ans.outcome = frlc_pkg::OC_EVICTED;
               end
               wr = (shadow_oldest + shadow_fill) % frlc_pkg::ENTRIES;
               shadow_key[wr]   = key;
               shadow_value[wr] = val;
               shadow_live[wr]  = 1'b1;
               shadow_fill++;
            end
         end
         frlc_pkg::REQ_CLEAR: begin
            empty_store();
            ans.outcome = frlc_pkg::OC_CLEARED;
         end
         default: ;
      endcase
      ans.hits      = shadow_hits;
      ans.misses    = shadow_misses;
      ans.occupancy = frlc_pkg::OCC_W'(shadow_fill);
      return ans;
   endfunction

   // call at a falling edge; returns at a falling edge with valid still high
   task automatic send_item(input logic [frlc_pkg::REQ_W-1:0]       kind,
                            input logic [frlc_pkg::KEY_WIDTH-1:0]   key,
                            input logic [frlc_pkg::VALUE_WIDTH-1:0] val);
      cache_answer_type ans;
      if (idling && $urandom_range(0, 3) == 0) begin
         req_ch.valid = 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_ch.req_type   = kind;
      req_ch.lookup_key = key;
      req_ch.value_in   = val;
      req_ch.valid      = 1'b1;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      ans = cache_answer(kind, key, val);
      pending_answers = {pending_answers, ans};
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_ch.valid = 1'b0;
      while (pending_answers.size() != 0) @(negedge clock);
   endtask

   task automatic set_capacity(input logic [frlc_pkg::CAP_W-1:0] cap);
      wait_drained();
      csr_wr_en   = 1'b1;
      csr_wr_data = cap;
      @(negedge clock);
      csr_wr_en   = 1'b0;
      shadow_capacity = cap;
   endtask

   task automatic send_random_request();
      logic [frlc_pkg::REQ_W-1:0]     kind;
      logic [frlc_pkg::KEY_WIDTH-1:0] key;
      int unsigned                    pick;
      int unsigned                    sel;
      pick = $urandom_range(0, 999);
      sel  = $urandom_range(0, 9);
      key  = $urandom;
      if (pick < 4) begin
         kind = frlc_pkg::REQ_CLEAR;
      end else if (pick < 24) begin
         kind = REQ_UNDEFINED;
      end else if (pick < 480) begin
         kind = frlc_pkg::REQ_INSERT;
      end else begin
         kind = frlc_pkg::REQ_LOOKUP;
      end
      if (kind == frlc_pkg::REQ_LOOKUP && sel < 6 && shadow_fill != 0) begin
         key = shadow_key[(shadow_oldest + $urandom_range(0, shadow_fill - 1)) %
                          frlc_pkg::ENTRIES];
      end else if ((kind == frlc_pkg::REQ_LOOKUP && sel < 8 ||
                    kind == frlc_pkg::REQ_INSERT && sel < 3)
                   && recent_keys.size() != 0) begin
         // reuse a key that may be live, evicted or duplicate
         key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
      end
      if (kind == frlc_pkg::REQ_INSERT) begin
         recent_keys = {recent_keys, key};
         if (recent_keys.size() > RECENT_DEPTH) void'(recent_keys.pop_front());
      end
      send_item(kind, key, $urandom);
   endtask

   task automatic test_empty_store();
      send_item(frlc_pkg::REQ_LOOKUP, '0, '0);
      send_item(REQ_UNDEFINED, '1, '1);
      send_item(frlc_pkg::REQ_CLEAR, '1, '0);
   endtask

   task automatic test_field_extremes();
      send_item(frlc_pkg::REQ_INSERT, '0, '1);
      send_item(frlc_pkg::REQ_INSERT, '1, '0);
      send_item(frlc_pkg::REQ_LOOKUP, '1, '1);
      send_item(frlc_pkg::REQ_LOOKUP, '0, '0);
      // duplicate must leave the stored value alone
      send_item(frlc_pkg::REQ_INSERT, '0, 32'h0000_0123);
      send_item(frlc_pkg::REQ_LOOKUP, '0, '0);
   endtask

   task automatic test_clear();
      send_item(frlc_pkg::REQ_CLEAR, 32'h5A5A_A5A5, 32'hA5A5_5A5A);
      send_item(frlc_pkg::REQ_LOOKUP, '0, '0);
   endtask

   task automatic test_capacity_zero();
      set_capacity(7'd0);
      send_item(frlc_pkg::REQ_INSERT, 32'h1111_0001, 32'hC0DE_0001);
      send_item(frlc_pkg::REQ_INSERT, 32'h1111_0002, 32'hC0DE_0002);
      send_item(frlc_pkg::REQ_LOOKUP, 32'h1111_0001, '0);
      send_item(frlc_pkg::REQ_LOOKUP, 32'h1111_0002, '0);
   endtask

   task automatic test_capacity_lowered();
      set_capacity(7'd64);
      send_item(frlc_pkg::REQ_CLEAR, '0, '0);
      for (int i = 0; i < 4; i++) begin
         send_item(frlc_pkg::REQ_INSERT, 32'h2222_0000 + i, 32'hBEEF_0000 + i);
      end
      set_capacity(7'd2);
      // occupancy holds at four: one out, one in
      send_item(frlc_pkg::REQ_INSERT, 32'h2222_0010, 32'hBEEF_0010);
      send_item(frlc_pkg::REQ_LOOKUP, 32'h2222_0001, '0);
      send_item(frlc_pkg::REQ_LOOKUP, 32'h2222_0000, '0);
   endtask

   task automatic test_random();
      logic [frlc_pkg::CAP_W-1:0] caps [PHASE_COUNT];
      caps = '{7'd127, 7'd64, 7'd1, 7'd65, 7'd2, 7'd0, 7'd9, 7'd0};
      caps[PHASE_COUNT-1] = frlc_pkg::CAP_W'($urandom_range(1, frlc_pkg::ENTRIES));
      for (int p = 0; p < PHASE_COUNT; p++) begin
         idling = (p != PHASE_COUNT - 1);
         set_capacity(caps[p]);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n == PHASE_ITEMS / 2) wait_drained();
            send_random_request();
         end
      end
   endtask

   always @(negedge clock) begin
      if (stall_left != 0) begin
         stall_left--;
         rsp_ch.ready = 1'b0;
      end else if (idling && $urandom_range(0, 5) == 0) begin
         stall_left   = $urandom_range(0, 11);
         rsp_ch.ready = 1'b0;
      end else begin
         rsp_ch.ready = 1'b1;
      end
   end

   always @(posedge clock) begin
      cache_answer_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_answers.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("unexpected response: outcome %0d value %h occupancy %0d",
                        rsp_ch.outcome, rsp_ch.value_out, rsp_ch.occupancy);
            end
         end else begin
            want = pending_answers.pop_front();
            if (rsp_ch.outcome !== want.outcome || rsp_ch.value_out !== want.value ||
                rsp_ch.hit_count !== want.hits || rsp_ch.miss_count !== want.misses ||
                rsp_ch.occupancy !== want.occupancy) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT) begin
                  $display("mismatch: expected outcome %0d value %h hits %0d misses %0d occ %0d",
                           want.outcome, want.value, want.hits, want.misses, want.occupancy);
                  $display("          actual   outcome %0d value %h hits %0d misses %0d occ %0d",
                           rsp_ch.outcome, rsp_ch.value_out, rsp_ch.hit_count,
                           rsp_ch.miss_count, rsp_ch.occupancy);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("fifo_replacement_lookup_cache_tb: errors");
         $finish;
      end
   end

   initial begin
      reset             = 1'b1;
      csr_wr_en         = 1'b0;
      csr_wr_data       = '0;
      req_ch.valid      = 1'b0;
      req_ch.req_type   = frlc_pkg::REQ_LOOKUP;
      req_ch.lookup_key = '0;
      req_ch.value_in   = '0;
      rsp_ch.ready      = 1'b0;
      idling            = 1'b0;
      stall_left        = 0;
      mismatches        = 0;
      cycle_count       = 0;
      empty_store();
      shadow_capacity = frlc_pkg::CAP_RESET;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset  = 1'b0;
      idling = 1'b1;

      test_empty_store();
      test_field_extremes();
      test_clear();
      test_capacity_zero();
      test_capacity_lowered();
      test_random();

      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatches == 0) begin
         $display("fifo_replacement_lookup_cache_tb: clean");
      end else begin
         $display("fifo_replacement_lookup_cache_tb: errors");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/frlc_pkg.sv
rtl/frlc_if.sv
rtl/frlc_ram.sv
rtl/fifo_replacement_lookup_cache.sv
test/fifo_replacement_lookup_cache_tb.sv
